// ----- rtl/wto_pkg.sv -----
`default_nettype none

package wto_pkg;

	// fixed field widths
	localparam int ADDR_W      = 11;
	localparam int LEN_W       = 12;
	localparam int STEP_W      = 20;
	localparam int MODE_W      = 2;
	localparam int GAIN_W      = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;

	// shortest table that the wrap logic accepts
	localparam int MIN_LEN = 4;

	// full-scale guard: |y| * GUARD_DEN >= GUARD_NUM * 2^(bits-1)
	localparam int GUARD_NUM = 9999;
	localparam int GUARD_DEN = 10000;

	// volume and pan are both Q1.15, so the product carries 30 fraction bits
	localparam int OUT_SHIFT = 30;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TABLE_LENGTH   = 3'd0,
		CFG_PHASE_STEP     = 3'd1,
		CFG_INTERP_MODE    = 3'd2,
		CFG_VOLUME_GAIN    = 3'd3,
		CFG_PAN_LEFT_GAIN  = 3'd4,
		CFG_PAN_RIGHT_GAIN = 3'd5
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LINEAR  = 2'd0,
		MODE_CUBIC   = 2'd1,
		MODE_HERMITE = 2'd2,
		MODE_SILENT  = 2'd3
	} interp_mode_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_TICK  = 1'b1
	} item_kind_t;

	localparam logic [LEN_W-1:0]  RST_TABLE_LENGTH = 12'd2048;
	localparam logic [STEP_W-1:0] RST_PHASE_STEP   = 20'd65536;
	localparam logic [GAIN_W-1:0] RST_GAIN         = 16'd32768;

endpackage

`default_nettype wire

// ----- rtl/wto_item_if.sv -----
`default_nettype none

interface wto_item_if import wto_pkg::*; #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	item_kind_t                    kind;
	logic [ADDR_W-1:0]             entry_address;
	logic signed [SAMPLE_BITS-1:0] entry_value;

	modport source (output valid, kind, entry_address, entry_value, input ready);
	modport sink (input valid, kind, entry_address, entry_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/wto_result_if.sv -----
`default_nettype none

interface wto_result_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          crack_muted;

	modport source (output valid, left_out, right_out, crack_muted, input ready);
	modport sink (input valid, left_out, right_out, crack_muted, output ready);
endinterface

`default_nettype wire

// ----- rtl/wto_mod_unit.sv -----
`default_nettype none

// restoring remainder, one trial subtract of span<<k per cycle
module wto_mod_unit #(
	parameter int X_W   = 28,
	parameter int D_W   = 28,
	parameter int STEPS = 10
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [X_W-1:0] x,
	input  wire logic [D_W-1:0] span,
	output logic                done,
	output logic [X_W-1:0]      rem
);

	localparam int C_W   = (X_W > D_W + STEPS - 1) ? X_W : D_W + STEPS - 1;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [X_W-1:0]   rem_q;
	logic [C_W-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [C_W-1:0]   rem_ext;
	logic             fits;

	assign rem_ext = C_W'(rem_q);
	assign fits    = (rem_ext >= div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			div_q <= C_W'(span) << (STEPS - 1);
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= X_W'(rem_ext - div_q);
			end
			div_q <= div_q >> 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/wavetable_oscillator_core.sv -----
`default_nettype none

// wavetable oscillator: table writes are taken one per cycle, back to back, while the sequencer is idle
// a tick steps through RD0-RD3, M0-M4, Y, ML, MR and FIN to its result; ticks wait
//   for idle, set by the sequencer that shares one multiplier and one table read port
// the first tick after a table_length write adds a reduction of the old phase
//   in S_NORM, with QB trial subtracts, QB = phase sum width - frac bits - 2
// reset: config registers to defaults, phase to zero; the table is undefined until written

module wavetable_oscillator_core import wto_pkg::*; #(
	parameter int TABLE_DEPTH     = 2048,
	parameter int SAMPLE_BITS     = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	wto_item_if.sink                    item,
	wto_result_if.source                result,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int FB     = PHASE_FRAC_BITS;
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int LW     = $clog2(TABLE_DEPTH + 1);
	// phase stays below TABLE_DEPTH entries
	localparam int PW     = IDX_W + FB;
	localparam int SPW    = LW + FB;
	// phase plus step, before the wrap
	localparam int SW     = ((PW > STEP_W) ? PW : STEP_W) + 1;
	// span is at least four entries, which bounds the quotient
	localparam int QB     = SW - FB - 2;
	// shared multiplier operands
	localparam int A_W    = (2 * GAIN_W + 1 > FB + 5) ? 2 * GAIN_W + 1 : FB + 5;
	localparam int B_W0   = (SB + 2 > FB + 1) ? SB + 2 : FB + 1;
	localparam int B_W    = (B_W0 > GAIN_W + 1) ? B_W0 : GAIN_W + 1;
	localparam int P_W    = A_W + B_W;
	localparam int ACC_W  = P_W + 2;
	localparam int H_W    = FB + 4;
	localparam int Y_W    = SB + 6;
	localparam int G_W    = Y_W + 14;

	localparam logic signed [H_W-1:0] ONE_H     = H_W'(1) << FB;
	localparam logic [G_W-1:0]        GUARD_LIM = G_W'(GUARD_NUM) << (SB - 1);
	localparam logic signed [P_W-1:0] SAT_HI    = P_W'((2 ** (SB - 1)) - 1);
	localparam logic signed [P_W-1:0] SAT_LO    = -(P_W'(2 ** (SB - 1)));

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM,
		S_RD0,
		S_RD1,
		S_RD2,
		S_RD3,
		S_M0,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_Y,
		S_ML,
		S_MR,
		S_FIN
	} state_t;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [LEN_W-1:0]  table_length_q;
	logic [STEP_W-1:0] phase_step_q;
	interp_mode_t      mode_q;
	logic [GAIN_W-1:0] volume_q;
	logic [GAIN_W-1:0] pan_left_q;
	logic [GAIN_W-1:0] pan_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= RST_TABLE_LENGTH;
			phase_step_q   <= RST_PHASE_STEP;
			mode_q         <= MODE_LINEAR;
			volume_q       <= RST_GAIN;
			pan_left_q     <= RST_GAIN;
			pan_right_q    <= RST_GAIN;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TABLE_LENGTH:   table_length_q <= cfg_data[LEN_W-1:0];
				CFG_PHASE_STEP:     phase_step_q   <= cfg_data[STEP_W-1:0];
				CFG_INTERP_MODE:    mode_q         <= interp_mode_t'(cfg_data[MODE_W-1:0]);
				CFG_VOLUME_GAIN:    volume_q       <= cfg_data[GAIN_W-1:0];
				CFG_PAN_LEFT_GAIN:  pan_left_q     <= cfg_data[GAIN_W-1:0];
				CFG_PAN_RIGHT_GAIN: pan_right_q    <= cfg_data[GAIN_W-1:0];
				default: ; // writes past the register list are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// effective length and wrapped neighbor addresses
	// ---------------------------------------------------------------
	logic [LW-1:0]    len;
	logic [SPW-1:0]   span;
	logic [PW-1:0]    phase_q;
	logic [IDX_W-1:0] idx;
	logic [FB-1:0]    t_frac;
	logic [IDX_W-1:0] idx_m1;
	logic [IDX_W-1:0] idx_p1;
	logic [IDX_W-1:0] idx_p2;
	logic [LW-1:0]    idx_p1_w;
	logic [LW-1:0]    idx_p2_w;

	// clamp to the range the table can hold
	always_comb begin
		if (table_length_q < LEN_W'(MIN_LEN)) begin
			len = LW'(MIN_LEN);
		end else if (32'(table_length_q) > 32'(TABLE_DEPTH)) begin
			len = LW'(TABLE_DEPTH);
		end else begin
			len = LW'(table_length_q);
		end
	end

	assign span   = {len, {FB{1'b0}}};
	assign idx    = phase_q[PW-1:FB];
	assign t_frac = phase_q[FB-1:0];

	// phase is already below the span whenever these are used
	assign idx_m1   = (idx == '0) ? IDX_W'(len - LW'(1)) : idx - IDX_W'(1);
	assign idx_p1_w = LW'(idx) + LW'(1);
	assign idx_p1   = (idx_p1_w == len) ? '0 : IDX_W'(idx_p1_w);
	assign idx_p2_w = LW'(idx_p1) + LW'(1);
	assign idx_p2   = (idx_p2_w == len) ? '0 : IDX_W'(idx_p2_w);

	// ---------------------------------------------------------------
	// handshake and sequencer control
	// ---------------------------------------------------------------
	state_t state_q;
	logic   dirty_q;       // table_length written since the phase was last reduced in S_NORM
	logic   tick_fire;
	logic   tbl_we;
	logic   addr_ok;

	assign item.ready = (state_q == S_IDLE);
	assign tick_fire  = item.valid && item.ready && (item.kind == KIND_TICK);
	assign addr_ok    = (32'(item.entry_address) < 32'(TABLE_DEPTH));
	assign tbl_we     = item.valid && item.ready && (item.kind == KIND_WRITE) && addr_ok;

	// ---------------------------------------------------------------
	// wave table: one write port, one registered read port
	// writes land only in idle, read data is used only while a tick runs, so they never meet
	// ---------------------------------------------------------------
	logic signed [SB-1:0] wave_mem [TABLE_DEPTH];
	logic signed [SB-1:0] rd_data_q;
	logic [IDX_W-1:0]     rd_addr;

	always_comb begin
		unique case (state_q)
			S_RD0:   rd_addr = idx_m1;
			S_RD1:   rd_addr = idx;
			S_RD2:   rd_addr = idx_p1;
			S_RD3:   rd_addr = idx_p2;
			default: rd_addr = idx;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			wave_mem[IDX_W'(item.entry_address)] <= item.entry_value;
		end
		rd_data_q <= wave_mem[rd_addr];
	end

	// ---------------------------------------------------------------
	// phase wrap unit
	// started at tick transfer when the length was written (reduce the old phase)
	// and again in the first read step (phase + step), finishing in the background
	// ---------------------------------------------------------------
	logic          mod_start;
	logic [SW-1:0] mod_x;
	logic          mod_done;
	logic [SW-1:0] mod_rem;

	assign mod_start = (tick_fire && dirty_q) || (state_q == S_RD0);
	assign mod_x     = (state_q == S_RD0) ? SW'(phase_q) + SW'(phase_step_q) : SW'(phase_q);

	wto_mod_unit #(
		.X_W   (SW),
		.D_W   (SPW),
		.STEPS (QB)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (mod_x),
		.span   (span),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// ---------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------
	logic signed [P_W-1:0]   prod_s;
	logic [FB-1:0]           t2_q;
	logic [FB-1:0]           t3_q;
	logic signed [SB-1:0]    ym1_q;
	logic signed [SB-1:0]    y0_q;
	logic signed [SB-1:0]    y1_q;
	logic signed [SB-1:0]    y2_q;
	logic [2*GAIN_W-1:0]     gl_q;
	logic [2*GAIN_W-1:0]     gr_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SB-1:0]    y_q;
	logic                    muted_q;
	logic signed [SB-1:0]    left_q;

	// ---------------------------------------------------------------
	// interpolation terms
	// ---------------------------------------------------------------
	logic [FB-1:0]          t2_now;
	logic [FB:0]            cub_c;     // t + t^2 - t^3, never negative
	logic signed [SB:0]     d_01;
	logic signed [SB:0]     d_m11;
	logic signed [SB:0]     d_02;
	logic signed [SB+1:0]   y0_x2;
	logic signed [SB+1:0]   y1_x2;
	logic signed [H_W-1:0]  th;
	logic signed [H_W-1:0]  t2h;
	logic signed [H_W-1:0]  t3h;
	logic signed [H_W-1:0]  h00;
	logic signed [H_W-1:0]  h10;
	logic signed [H_W-1:0]  h01;
	logic signed [H_W-1:0]  h11;

	assign t2_now = prod_s[2*FB-1:FB];
	assign cub_c  = (FB+1)'(t_frac) + (FB+1)'(t2_q) - (FB+1)'(t3_q);
	assign d_01   = (SB+1)'(y1_q) - (SB+1)'(y0_q);
	assign d_m11  = (SB+1)'(y1_q) - (SB+1)'(ym1_q);
	assign d_02   = (SB+1)'(y2_q) - (SB+1)'(y0_q);
	assign y0_x2  = (SB+2)'(y0_q) <<< 1;
	assign y1_x2  = (SB+2)'(y1_q) <<< 1;
	assign th     = H_W'(t_frac);
	assign t2h    = H_W'(t2_q);
	assign t3h    = H_W'(t3_q);

	// hermite basis with catmull-rom tangents folded into the sample terms
	assign h00 = (t3h <<< 1) - (t2h + (t2h <<< 1)) + ONE_H;
	assign h10 = t3h - (t2h <<< 1) + th;
	assign h01 = (t2h + (t2h <<< 1)) - (t3h <<< 1);
	assign h11 = t3h - t2h;

	// ---------------------------------------------------------------
	// shared multiplier operand select, one product per cycle
	// ---------------------------------------------------------------
	logic signed [A_W-1:0] mul_a;
	logic signed [B_W-1:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_RD0: begin
				mul_a = A_W'(t_frac);
				mul_b = B_W'(t_frac);
			end
			S_RD1: begin
				mul_a = A_W'(t2_now);
				mul_b = B_W'(t_frac);
			end
			S_RD2: begin
				mul_a = A_W'(volume_q);
				mul_b = B_W'(pan_left_q);
			end
			S_RD3: begin
				mul_a = A_W'(volume_q);
				mul_b = B_W'(pan_right_q);
			end
			S_M0: begin
				unique case (mode_q)
					MODE_LINEAR: begin
						mul_a = A_W'(t_frac);
						mul_b = B_W'(d_01);
					end
					MODE_CUBIC: begin
						mul_a = A_W'(cub_c);
						mul_b = B_W'(d_01);
					end
					MODE_HERMITE: begin
						mul_a = A_W'(h00);
						mul_b = B_W'(y0_x2);
					end
					default: ;
				endcase
			end
			S_M1: begin
				if (mode_q == MODE_HERMITE) begin
					mul_a = A_W'(h10);
					mul_b = B_W'(d_m11);
				end
			end
			S_M2: begin
				if (mode_q == MODE_HERMITE) begin
					mul_a = A_W'(h01);
					mul_b = B_W'(y1_x2);
				end
			end
			S_M3: begin
				if (mode_q == MODE_HERMITE) begin
					mul_a = A_W'(h11);
					mul_b = B_W'(d_02);
				end
			end
			S_ML: begin
				mul_a = A_W'(gl_q);
				mul_b = B_W'(y_q);
			end
			S_MR, S_FIN: begin
				// held through the final step so the right product stays put
				mul_a = A_W'(gr_q);
				mul_b = B_W'(y_q);
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// interpolated sample and full-scale guard
	// ---------------------------------------------------------------
	logic signed [ACC_W-1:0] acc_lin;
	logic signed [ACC_W-1:0] acc_her;
	logic signed [Y_W-1:0]   y_calc;
	logic [Y_W-1:0]          y_mag;
	logic [G_W-1:0]          guard_prod;
	logic                    guard_hit;

	assign acc_lin = acc_q >>> FB;
	assign acc_her = acc_q >>> (FB + 1);

	always_comb begin
		unique case (mode_q)
			MODE_LINEAR, MODE_CUBIC: y_calc = Y_W'(acc_lin) + Y_W'(y0_q);
			MODE_HERMITE:            y_calc = Y_W'(acc_her);
			default:                 y_calc = '0;
		endcase
	end

	assign y_mag      = y_calc[Y_W-1] ? Y_W'(-y_calc) : Y_W'(y_calc);
	assign guard_prod = G_W'(y_mag) * G_W'(GUARD_DEN);
	assign guard_hit  = (guard_prod >= GUARD_LIM);

	// ---------------------------------------------------------------
	// output scale and saturation
	// ---------------------------------------------------------------
	logic signed [P_W-1:0] prod_sh;
	logic signed [SB-1:0]  sat_val;

	assign prod_sh = prod_s >>> OUT_SHIFT;

	always_comb begin
		if (prod_sh > SAT_HI) begin
			sat_val = {1'b0, {(SB-1){1'b1}}};
		end else if (prod_sh < SAT_LO) begin
			sat_val = {1'b1, {(SB-1){1'b0}}};
		end else begin
			sat_val = prod_sh[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s <= mul_a * mul_b;
		unique case (state_q)
			S_RD1: begin
				ym1_q <= rd_data_q;
				t2_q  <= t2_now;
			end
			S_RD2: begin
				y0_q <= rd_data_q;
				t3_q <= prod_s[2*FB-1:FB];
			end
			S_RD3: begin
				y1_q <= rd_data_q;
				gl_q <= prod_s[2*GAIN_W-1:0];
			end
			S_M0: begin
				y2_q <= rd_data_q;
				gr_q <= prod_s[2*GAIN_W-1:0];
			end
			S_M1:             acc_q <= ACC_W'(prod_s);
			S_M2, S_M3, S_M4: acc_q <= acc_q + ACC_W'(prod_s);
			S_Y: begin
				y_q     <= guard_hit ? '0 : SB'(y_calc);
				muted_q <= guard_hit;
			end
			S_MR:    left_q <= sat_val;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// sequencer, phase register and output register
	// ---------------------------------------------------------------
	logic                 res_valid_q;
	logic signed [SB-1:0] res_left_q;
	logic signed [SB-1:0] res_right_q;
	logic                 res_muted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dirty_q     <= 1'b0;
			phase_q     <= '0;
			res_valid_q <= 1'b0;
			res_left_q  <= '0;
			res_right_q <= '0;
			res_muted_q <= 1'b0;
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_write_en && (cfg_reg_t'(cfg_index) == CFG_TABLE_LENGTH)) begin
				dirty_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tick_fire) begin
						state_q <= dirty_q ? S_NORM : S_RD0;
					end
				end
				S_NORM: begin
					if (mod_done) begin
						phase_q <= PW'(mod_rem);
						dirty_q <= 1'b0;
						state_q <= S_RD0;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_M0;
				S_M0:  state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_M4;
				S_M4:  state_q <= S_Y;
				S_Y:   state_q <= S_ML;
				S_ML:  state_q <= S_MR;
				S_MR:  state_q <= S_FIN;
				S_FIN: begin
					// wait for the wrapped phase and a free output register
					if (mod_done && (!res_valid_q || result.ready)) begin
						res_valid_q <= 1'b1;
						res_left_q  <= left_q;
						res_right_q <= sat_val;
						res_muted_q <= muted_q;
						phase_q     <= PW'(mod_rem);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid       = res_valid_q;
	assign result.left_out    = res_left_q;
	assign result.right_out   = res_right_q;
	assign result.crack_muted = res_muted_q;

endmodule

`default_nettype wire
